### rtl/lecb_pkg.sv
// ----------------------------------------------------------------------------
// lecb_pkg
// Shared types and constants for the line edit cursor buffer.
// ----------------------------------------------------------------------------
package lecb_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [3:0] KIND_INSERT    = 4'd0;
    localparam logic [3:0] KIND_DELETE    = 4'd1;
    localparam logic [3:0] KIND_BACKSPACE = 4'd2;
    localparam logic [3:0] KIND_HOME      = 4'd3;
    localparam logic [3:0] KIND_END       = 4'd4;
    localparam logic [3:0] KIND_NEXT      = 4'd5;
    localparam logic [3:0] KIND_PREV      = 4'd6;
    localparam logic [3:0] KIND_CLEAR     = 4'd7;
    localparam logic [3:0] KIND_READ      = 4'd8;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] char_in;
        logic [5:0] read_index;
    } cmd_t;

    typedef struct packed {
        logic [6:0] cursor_pos;
        logic [6:0] text_length;
        logic [7:0] char_out;
        logic       applied;
    } result_t;

endpackage

### rtl/line_edit_cursor_buffer_top.sv
// ----------------------------------------------------------------------------
// line_edit_cursor_buffer_top
// Bounded line editor with a cursor over a text memory with one read and
// one write port.
// ----------------------------------------------------------------------------
// Takes one edit command word at a time and returns one result word per
// command. Insert, delete and backspace move the bytes behind the cursor
// one place through the text memory, one byte per cycle; the bytes moved
// are length - cursor for insert and backspace and one fewer for delete.
// A new command is taken once the previous result has been handed to the
// output register, which holds it until the sink takes it. Text bytes are
// undefined after reset until written; only bytes below the length are
// ever returned.
module line_edit_cursor_buffer_top
    import lecb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  cmd_t    in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int ADDR_W = $clog2(CAPACITY);

    logic              done_valid;
    logic              done_ready;
    result_t           done_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    logic              out_valid_reg;
    result_t           out_data_reg;

    lecb_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done_data  (done_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    lecb_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // output word register
    assign done_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_ready)
        begin
            out_valid_reg <= done_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ready && done_valid)
        begin
            out_data_reg <= done_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/lecb_store.sv
// ----------------------------------------------------------------------------
// lecb_store
// Text memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lecb_store
    import lecb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int ADDR_W = $clog2(CAPACITY)
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data
);

    logic [7:0] store_mem [CAPACITY];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lecb_ctrl.sv
// ----------------------------------------------------------------------------
// lecb_ctrl
// Command sequencer: decodes one edit command, steps the shift pointer
// through the memory one byte per cycle, and updates cursor and length.
// ----------------------------------------------------------------------------
module lecb_ctrl
    import lecb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int ADDR_W = $clog2(CAPACITY),
    localparam int CNT_W  = $clog2(CAPACITY + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cmd_t              in_data,
    output logic              done_valid,
    input  logic              done_ready,
    output result_t           done_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SHIFT  = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_DONE   = 3'd3;

    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  caret_reg, caret_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [3:0]        kind_reg, kind_next;
    logic [7:0]        char_reg, char_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              up_reg, up_next;
    logic              wpend_reg, wpend_next;
    logic [ADDR_W-1:0] waddr_reg, waddr_next;
    logic              applied_reg, applied_next;
    logic [7:0]        char_out_reg, char_out_next;

    logic              accept;
    logic              read_ok;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign read_ok  = CMP_W'(in_data.read_index) < CMP_W'(fill_reg);

    always_comb
    begin
        state_next    = state_reg;
        caret_next    = caret_reg;
        fill_next     = fill_reg;
        kind_next     = kind_reg;
        char_next     = char_reg;
        ptr_next      = ptr_reg;
        left_next     = left_reg;
        up_next       = up_reg;
        wpend_next    = wpend_reg;
        waddr_next    = waddr_reg;
        applied_next  = applied_reg;
        char_out_next = char_out_reg;
        rd_en         = 1'b0;
        rd_addr       = ADDR_W'(ptr_reg);
        wr_en         = 1'b0;
        wr_addr       = waddr_reg;
        wr_data       = rd_data;
        done_valid    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next     = in_data.kind;
                    char_next     = in_data.char_in;
                    char_out_next = 8'd0;
                    applied_next  = 1'b0;
                    wpend_next    = 1'b0;
                    state_next    = ST_DONE;
                    unique case (in_data.kind)
                        KIND_INSERT:
                        begin
                            if (fill_reg < CNT_W'(CAPACITY))
                            begin
                                // bytes from the cursor up move one place higher
                                left_next    = fill_reg - caret_reg;
                                ptr_next     = fill_reg - CNT_W'(1);
                                up_next      = 1'b1;
                                applied_next = 1'b1;
                                state_next   = ST_SHIFT;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (caret_reg < fill_reg)
                            begin
                                left_next    = fill_reg - caret_reg - CNT_W'(1);
                                ptr_next     = caret_reg + CNT_W'(1);
                                up_next      = 1'b0;
                                applied_next = 1'b1;
                                state_next   = ST_SHIFT;
                            end
                        end
                        KIND_BACKSPACE:
                        begin
                            if (caret_reg != '0)
                            begin
                                left_next    = fill_reg - caret_reg;
                                ptr_next     = caret_reg;
                                up_next      = 1'b0;
                                applied_next = 1'b1;
                                state_next   = ST_SHIFT;
                            end
                        end
                        KIND_HOME:
                        begin
                            caret_next   = '0;
                            applied_next = 1'b1;
                        end
                        KIND_END:
                        begin
                            caret_next   = fill_reg;
                            applied_next = 1'b1;
                        end
                        KIND_NEXT:
                        begin
                            if (caret_reg < fill_reg)
                            begin
                                caret_next   = caret_reg + CNT_W'(1);
                                applied_next = 1'b1;
                            end
                        end
                        KIND_PREV:
                        begin
                            if (caret_reg != '0)
                            begin
                                caret_next   = caret_reg - CNT_W'(1);
                                applied_next = 1'b1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            caret_next   = '0;
                            fill_next    = '0;
                            applied_next = 1'b1;
                        end
                        KIND_READ:
                        begin
                            if (read_ok)
                            begin
                                rd_en        = 1'b1;
                                rd_addr      = ADDR_W'(in_data.read_index);
                                applied_next = 1'b1;
                                state_next   = ST_RDWAIT;
                            end
                        end
                        default:
                        begin
                            applied_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_SHIFT:
            begin
                // read one byte ahead, write it one place along in the next cycle
                if (wpend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = waddr_reg;
                    wr_data = rd_data;
                end
                if (left_reg != '0)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(ptr_reg);
                    wpend_next = 1'b1;
                    waddr_next = up_reg ? ADDR_W'(ptr_reg + CNT_W'(1))
                                        : ADDR_W'(ptr_reg - CNT_W'(1));
                    ptr_next   = up_reg ? ptr_reg - CNT_W'(1) : ptr_reg + CNT_W'(1);
                    left_next  = left_reg - CNT_W'(1);
                end
                else
                begin
                    wpend_next = 1'b0;
                    if (!wpend_reg)
                    begin
                        state_next = ST_DONE;
                        unique case (kind_reg)
                            KIND_INSERT:
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = ADDR_W'(caret_reg);
                                wr_data    = char_reg;
                                caret_next = caret_reg + CNT_W'(1);
                                fill_next  = fill_reg + CNT_W'(1);
                            end
                            KIND_DELETE:
                            begin
                                fill_next = fill_reg - CNT_W'(1);
                            end
                            KIND_BACKSPACE:
                            begin
                                caret_next = caret_reg - CNT_W'(1);
                                fill_next  = fill_reg - CNT_W'(1);
                            end
                            default:
                            begin
                                fill_next = fill_reg;
                            end
                        endcase
                    end
                end
            end

            ST_RDWAIT:
            begin
                char_out_next = rd_data;
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                done_valid = 1'b1;
                if (done_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done_data.cursor_pos  = 7'(caret_reg);
    assign done_data.text_length = 7'(fill_reg);
    assign done_data.char_out    = char_out_reg;
    assign done_data.applied     = applied_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            caret_reg <= '0;
            fill_reg  <= '0;
            left_reg  <= '0;
            wpend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            caret_reg <= caret_next;
            fill_reg  <= fill_next;
            left_reg  <= left_next;
            wpend_reg <= wpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        char_reg     <= char_next;
        ptr_reg      <= ptr_next;
        up_reg       <= up_next;
        waddr_reg    <= waddr_next;
        applied_reg  <= applied_next;
        char_out_reg <= char_out_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        caret_reg <= fill_reg)
        else $error("cursor beyond end of text");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wpend_reg)
        else $error("write pending while idle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("ready right after a command was taken");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !wpend_reg) |-> (state_reg == ST_SHIFT && kind_reg == KIND_INSERT))
        else $error("unexpected memory write");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line edit cursor buffer.
// Edit commands are sent over a valid/ready channel. A mirror of the text,
// the cursor and the length gives the expected result word for each accepted
// command, and every returned word is checked field by field against it.
// The run has directed corner cases, a fill past capacity, and random editing
// under several sender and receiver idling profiles.
// ----------------------------------------------------------------------------
module testbench
    import lecb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_CAP    = CAPACITY_DEF;
    localparam int IDLE_LIMIT  = 4000;  // cycles with no word moving on either side
    localparam int DRAIN_WAIT  = TEXT_CAP + 16;

    // command codes with no meaning
    localparam logic [3:0] KIND_SPARE_LO = KIND_READ + 4'd1;
    localparam logic [3:0] KIND_SPARE_HI = 4'hf;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    cmd_t    in_data = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    result_t out_data;

    // mirror of the block's state
    logic [7:0]  text_mirror [TEXT_CAP];
    int unsigned mirror_cursor;
    int unsigned mirror_length;

    result_t     expected_results [$];
    int          failures = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    line_edit_cursor_buffer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Applies one command to the mirror and returns the word it should produce.
    function automatic result_t edit_text(cmd_t c);
        result_t r;
        r = '0;
        case (c.kind)
            KIND_INSERT:
                if (mirror_length < TEXT_CAP)
                begin
                    for (int i = mirror_length; i > mirror_cursor; i--)
                        text_mirror[i] = text_mirror[i - 1];
                    text_mirror[mirror_cursor] = c.char_in;
                    mirror_cursor++;
                    mirror_length++;
                    r.applied = 1'b1;
                end
            KIND_DELETE:
                if (mirror_cursor < mirror_length)
                begin
                    for (int i = mirror_cursor; i + 1 < mirror_length; i++)
                        text_mirror[i] = text_mirror[i + 1];
                    mirror_length--;
                    r.applied = 1'b1;
                end
            KIND_BACKSPACE:
                if (mirror_cursor > 0)
                begin
                    for (int i = mirror_cursor - 1; i + 1 < mirror_length; i++)
                        text_mirror[i] = text_mirror[i + 1];
                    mirror_cursor--;
                    mirror_length--;
                    r.applied = 1'b1;
                end
            KIND_HOME:
            begin
                mirror_cursor = 0;
                r.applied = 1'b1;
            end
            KIND_END:
            begin
                mirror_cursor = mirror_length;
                r.applied = 1'b1;
            end
            KIND_NEXT:
                if (mirror_cursor < mirror_length)
                begin
                    mirror_cursor++;
                    r.applied = 1'b1;
                end
            KIND_PREV:
                if (mirror_cursor > 0)
                begin
                    mirror_cursor--;
                    r.applied = 1'b1;
                end
            KIND_CLEAR:
            begin
                mirror_cursor = 0;
                mirror_length = 0;
                r.applied = 1'b1;
            end
            KIND_READ:
                if (c.read_index < mirror_length)
                begin
                    r.char_out = text_mirror[c.read_index];
                    r.applied = 1'b1;
                end
            default: ;
        endcase
        r.cursor_pos  = mirror_cursor[6:0];
        r.text_length = mirror_length[6:0];
        return r;
    endfunction

    // Offers one word; returns at the edge where it is taken.
    task automatic send_cmd(input cmd_t c);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
        expected_results.push_back(edit_text(c));
    endtask

    task automatic send_kind(input logic [3:0] kind, input logic [7:0] ch,
                             input logic [5:0] idx);
        cmd_t c;
        c.kind       = kind;
        c.char_in    = ch;
        c.read_index = idx;
        send_cmd(c);
    endtask

    function automatic cmd_t random_edit(int insert_pct);
        cmd_t c;
        int   pick;
        c.char_in    = 8'($urandom_range(255, 0));
        c.read_index = 6'($urandom_range(63, 0));
        if ($urandom_range(99, 0) < insert_pct)
            c.kind = KIND_INSERT;
        else
        begin
            pick = $urandom_range(99, 0);
            if (pick < 18)      c.kind = KIND_DELETE;
            else if (pick < 36) c.kind = KIND_BACKSPACE;
            else if (pick < 48) c.kind = KIND_NEXT;
            else if (pick < 60) c.kind = KIND_PREV;
            else if (pick < 66) c.kind = KIND_HOME;
            else if (pick < 72) c.kind = KIND_END;
            else if (pick < 75) c.kind = KIND_CLEAR;
            else if (pick < 95) c.kind = KIND_READ;
            else                c.kind = 4'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        end
        // mostly read bytes that are actually held
        if (c.kind == KIND_READ && mirror_length != 0 && $urandom_range(3, 0) != 0)
            c.read_index = 6'($urandom_range(mirror_length - 1, 0));
        return c;
    endfunction

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_directed();
        send_kind(KIND_READ, 8'h00, 6'd0);        // read on empty text
        send_kind(KIND_DELETE, 8'hff, 6'd63);     // nothing to delete
        send_kind(KIND_BACKSPACE, 8'h00, 6'd0);   // nothing before cursor
        send_kind(KIND_NEXT, 8'h00, 6'd0);
        send_kind(KIND_PREV, 8'h00, 6'd0);
        send_kind(KIND_INSERT, 8'h00, 6'd0);
        send_kind(KIND_INSERT, 8'hff, 6'd63);
        send_kind(KIND_INSERT, 8'ha5, 6'd21);
        send_kind(KIND_HOME, 8'h00, 6'd0);
        send_kind(KIND_NEXT, 8'h00, 6'd0);
        send_kind(KIND_INSERT, 8'h5a, 6'd42);     // mid insert, tail shifts up
        send_kind(KIND_READ, 8'h00, 6'd1);
        send_kind(KIND_READ, 8'hff, 6'd63);       // index past length
        send_kind(KIND_END, 8'h00, 6'd0);
        send_kind(KIND_PREV, 8'h00, 6'd0);
        send_kind(KIND_BACKSPACE, 8'h00, 6'd0);   // mid backspace
        send_kind(KIND_HOME, 8'h00, 6'd0);
        send_kind(KIND_DELETE, 8'h00, 6'd0);      // delete at start
        send_kind(KIND_READ, 8'h00, 6'd0);
        send_kind(KIND_END, 8'h00, 6'd0);
        send_kind(KIND_DELETE, 8'h00, 6'd0);      // at end: ignored
        send_kind(KIND_SPARE_LO, 8'h3c, 6'd9);    // unused kinds
        send_kind(KIND_SPARE_HI, 8'hc3, 6'd54);
        send_kind(KIND_CLEAR, 8'h00, 6'd0);
        send_kind(KIND_HOME, 8'h00, 6'd0);
    endtask

    task automatic test_fill_to_capacity();
        cmd_t c;
        send_kind(KIND_CLEAR, 8'h00, 6'd0);
        while (mirror_length < TEXT_CAP)
        begin
            c.char_in    = 8'($urandom_range(255, 0));
            c.read_index = 6'($urandom_range(63, 0));
            case ($urandom_range(7, 0))
                0:       c.kind = KIND_PREV;
                1:       c.kind = KIND_NEXT;
                default: c.kind = KIND_INSERT;
            endcase
            send_cmd(c);
        end
        repeat (3)
            send_kind(KIND_INSERT, 8'($urandom_range(255, 0)), 6'($urandom_range(63, 0)));
        send_kind(KIND_READ, 8'h00, 6'd63);
        send_kind(KIND_READ, 8'h00, 6'd0);
        repeat (8)
            send_kind(KIND_READ, 8'($urandom_range(255, 0)), 6'($urandom_range(63, 0)));
        while (mirror_length != 0)
        begin
            c.char_in    = 8'($urandom_range(255, 0));
            c.read_index = 6'($urandom_range(63, 0));
            case ($urandom_range(5, 0))
                0:       c.kind = KIND_PREV;
                1:       c.kind = KIND_NEXT;
                2, 3:    c.kind = KIND_DELETE;
                default: c.kind = KIND_BACKSPACE;
            endcase
            send_cmd(c);
        end
    endtask

    task automatic test_random_edit(input int count);
        int insert_pct;
        insert_pct = 40;
        for (int n = 0; n < count; n++)
        begin
            // growth bias changes in bursts so the length sweeps its range
            if (n % 40 == 0)
            begin
                case ($urandom_range(2, 0))
                    0:       insert_pct = 20;
                    1:       insert_pct = 40;
                    default: insert_pct = 60;
                endcase
            end
            send_cmd(random_edit(insert_pct));
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // result checker: sampled mid-cycle, the word moves at the next rising edge
    initial
    begin
        result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with none expected");
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("cursor_pos", 8'(want.cursor_pos),
                                8'(out_data.cursor_pos));
                    check_field("text_length", 8'(want.text_length),
                                8'(out_data.text_length));
                    check_field("char_out", want.char_out, out_data.char_out);
                    check_field("applied", 8'(want.applied), 8'(out_data.applied));
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        mirror_cursor = 0;
        mirror_length = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_directed();
        test_fill_to_capacity();
        test_random_edit(340);
        set_idling(81, 0);
        test_random_edit(340);
        set_idling(0, 81);
        test_random_edit(340);
        test_fill_to_capacity();
        set_idling(7, 7);
        test_random_edit(340);

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
